@@ rtl/tli_pkg.sv @@
// Shared types and constants for the table linear interpolator.
package tli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam int PIU_W       = 7;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

    localparam logic [PADDR_W-3:0] REG_POINTS_IN_USE = '0;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_DROP,
        CMD_SHORT,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  energy;
        logic [DATA_W-1:0]  mu;
        logic [ADDR_W-1:0]  last;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] energy;
        logic [DATA_W-1:0] mu;
    } entry_t;

endpackage

@@ rtl/tli_ram.sv @@
// Generic single-port-write, registered-read RAM.
module tli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/tli_front.sv @@
// Front end: APB register, transaction classification and command queue.
module tli_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tli_pkg::PADDR_W-1:0]   paddr,
    input  logic [tli_pkg::PDATA_W-1:0]   pwdata,
    output logic [tli_pkg::PDATA_W-1:0]   prdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [tli_pkg::INDEX_W-1:0]   s_point_index,
    input  logic [tli_pkg::DATA_W-1:0]    s_point_energy,
    input  logic [tli_pkg::DATA_W-1:0]    s_point_mu,
    input  logic [tli_pkg::DATA_W-1:0]    s_query_energy,
    output logic                          q_valid,
    output tli_pkg::cmd_t                 q_cmd,
    input  logic                          q_pop
);
    import tli_pkg::*;

    logic [PIU_W-1:0]  points_in_use_reg;
    logic              reg_sel;
    logic [CNT_W-1:0]  n_eff;
    cmd_t              cmd_in;
    logic              push;

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign reg_sel = (paddr[PADDR_W-1:2] == REG_POINTS_IN_USE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_in_use_reg <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            points_in_use_reg <= pwdata[PIU_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(points_in_use_reg) : '0;

    always_comb begin
        if (32'(points_in_use_reg) > TABLE_DEPTH) begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end else begin
            n_eff = CNT_W'(points_in_use_reg);
        end
        cmd_in.addr = ADDR_W'(s_point_index);
        cmd_in.mu   = s_point_mu;
        cmd_in.last = ADDR_W'(n_eff - CNT_W'(1));
        if (s_operation == OP_WRITE) begin
            cmd_in.energy = s_point_energy;
            cmd_in.kind   = (32'(s_point_index) < TABLE_DEPTH) ? CMD_WRITE : CMD_DROP;
        end else begin
            cmd_in.energy = s_query_energy;
            cmd_in.kind   = (n_eff < CNT_W'(2)) ? CMD_SHORT : CMD_QUERY;
        end
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = queue_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                queue_reg[wr_ptr_reg] <= cmd_in;
                wr_ptr_reg            <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (!push && q_pop) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (count_reg != '0))
        else $error("command queue popped while empty");

endmodule

@@ rtl/tli_back.sv @@
// Back end: table store, segment scan, serial divider and result register.
module tli_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  tli_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tli_pkg::DATA_W-1:0]    m_mu_result,
    output logic [tli_pkg::STATUS_W-1:0]  m_status
);
    import tli_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAST,
        ST_FIRST,
        ST_CHECK,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic [ADDR_W-1:0]      last_reg;
    logic [DATA_W-1:0]      e_reg;
    logic [DATA_W-1:0]      x_last_reg;
    logic [DATA_W-1:0]      mu_last_reg;
    logic [DATA_W-1:0]      prev_x_reg;
    logic [DATA_W-1:0]      prev_mu_reg;
    logic [DATA_W-1:0]      x0_reg;
    logic [DATA_W-1:0]      x1_reg;
    logic [DATA_W-1:0]      y0_reg;
    logic [DATA_W-1:0]      y1_reg;
    logic [DATA_W-1:0]      dx_reg;
    logic [DATA_W-1:0]      off_reg;
    logic [DATA_W-1:0]      dy_reg;
    logic                   neg_reg;
    logic [DATA_W-1:0]      rem_reg;
    logic [DATA_W-1:0]      quo_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DATA_W-1:0]      res_mu_reg;
    logic [STATUS_W-1:0]    res_st_reg;
    logic                   m_valid_reg;
    logic [DATA_W-1:0]      m_mu_result_reg;
    logic [STATUS_W-1:0]    m_status_reg;

    logic                   wr_en;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t                 rd_entry;
    entry_t                 wr_entry;
    logic                   hit;
    logic [2*DATA_W-1:0]    prod;
    logic [DATA_W:0]        rem_sh;
    logic                   ge;
    logic [DATA_W-1:0]      rem_next;
    logic [DATA_W-1:0]      quo_next;
    logic                   out_free;

    assign q_pop           = (state_reg == ST_IDLE) && q_valid;
    assign wr_en           = q_pop && (q_cmd.kind == CMD_WRITE);
    assign wr_entry.energy = q_cmd.energy;
    assign wr_entry.mu     = q_cmd.mu;
    assign rd_entry        = rd_data;

    tli_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (q_cmd.addr),
        .wr_data (wr_entry),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign hit      = (e_reg >= prev_x_reg) && (e_reg <= rd_entry.energy);
    assign prod     = (2*DATA_W)'(off_reg) * (2*DATA_W)'(dy_reg);
    assign rem_sh   = {rem_reg, quo_reg[DATA_W-1]};
    assign ge       = (rem_sh >= {1'b0, dx_reg});
    assign rem_next = ge ? DATA_W'(rem_sh - {1'b0, dx_reg}) : rem_sh[DATA_W-1:0];
    assign quo_next = {quo_reg[DATA_W-2:0], ge};
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        e_reg      <= q_cmd.energy;
                        last_reg   <= q_cmd.last;
                        addr_reg   <= q_cmd.last;
                        res_mu_reg <= '0;
                        res_st_reg <= (q_cmd.kind == CMD_SHORT) ? STATUS_SHORT : STATUS_OK;
                        state_reg  <= (q_cmd.kind == CMD_QUERY) ? ST_LAST : ST_DONE;
                    end
                end
                ST_LAST: begin
                    addr_reg  <= '0;
                    state_reg <= ST_FIRST;
                end
                ST_FIRST: begin
                    x_last_reg  <= rd_entry.energy;
                    mu_last_reg <= rd_entry.mu;
                    addr_reg    <= addr_reg + ADDR_W'(1);
                    state_reg   <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (e_reg < rd_entry.energy || e_reg > x_last_reg) begin
                        res_st_reg <= STATUS_RANGE;
                        state_reg  <= ST_DONE;
                    end else begin
                        prev_x_reg  <= rd_entry.energy;
                        prev_mu_reg <= rd_entry.mu;
                        idx_reg     <= ADDR_W'(1);
                        addr_reg    <= addr_reg + ADDR_W'(1);
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        x0_reg    <= prev_x_reg;
                        y0_reg    <= prev_mu_reg;
                        x1_reg    <= rd_entry.energy;
                        y1_reg    <= rd_entry.mu;
                        state_reg <= ST_PREP;
                    end else if (idx_reg == last_reg) begin
                        res_mu_reg <= mu_last_reg;
                        state_reg  <= ST_DONE;
                    end else begin
                        prev_x_reg  <= rd_entry.energy;
                        prev_mu_reg <= rd_entry.mu;
                        idx_reg     <= idx_reg + ADDR_W'(1);
                        addr_reg    <= addr_reg + ADDR_W'(1);
                    end
                end
                ST_PREP: begin
                    dx_reg  <= x1_reg - x0_reg;
                    off_reg <= e_reg - x0_reg;
                    neg_reg <= (y1_reg < y0_reg);
                    dy_reg  <= (y1_reg < y0_reg) ? (y0_reg - y1_reg) : (y1_reg - y0_reg);
                    if (x1_reg == x0_reg) begin
                        res_mu_reg <= y0_reg;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // offset never exceeds the segment width, so the high half is below dx
                    rem_reg     <= prod[2*DATA_W-1:DATA_W];
                    quo_reg     <= prod[DATA_W-1:0];
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg     <= rem_next;
                    quo_reg     <= quo_next;
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DATA_W - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    res_mu_reg <= neg_reg ? (y0_reg - quo_reg) : (y0_reg + quo_reg);
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_mu_result_reg <= res_mu_reg;
                        m_status_reg    <= res_st_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_mu_result = m_mu_result_reg;
    assign m_status    = m_status_reg;

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dx_reg != '0))
        else $error("divider running on a zero-width segment");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < dx_reg))
        else $error("partial remainder not below divisor");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= last_reg))
        else $error("scan ran past last point in use");

    a_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg != ST_IDLE))
        else $error("command popped without starting work");

endmodule

@@ rtl/table_linear_interpolator_core.sv @@
// Top level of the piecewise-linear interpolation table.
//
//  channel   direction  handshake               payload
//  s_        in         s_valid / s_ready       operation, point_index, point_energy,
//                                               point_mu, query_energy
//  m_        out        m_valid / m_ready       mu_result, status
//  apb       in/out     psel, penable, pready   points_in_use at byte address 0
//
// Writes and short-table queries go straight to the result register. Other queries read the
// last and first points for the range check, then scan the segments; a match on a segment
// of nonzero width is then multiplied and divided before the result is registered. Here
// the scan reads one table entry per cycle, the divider retires one quotient bit per cycle.
// The two-entry queue takes transactions, until full, while the back end works or m_ stalls.
// Reset clears control state only; table entries read as undefined until written.
module table_linear_interpolator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tli_pkg::PADDR_W-1:0]   paddr,
    input  logic [tli_pkg::PDATA_W-1:0]   pwdata,
    output logic [tli_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [tli_pkg::INDEX_W-1:0]   s_point_index,
    input  logic [tli_pkg::DATA_W-1:0]    s_point_energy,
    input  logic [tli_pkg::DATA_W-1:0]    s_point_mu,
    input  logic [tli_pkg::DATA_W-1:0]    s_query_energy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tli_pkg::DATA_W-1:0]    m_mu_result,
    output logic [tli_pkg::STATUS_W-1:0]  m_status
);
    import tli_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    assign pready = 1'b1;

    tli_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_point_index  (s_point_index),
        .s_point_energy (s_point_energy),
        .s_point_mu     (s_point_mu),
        .s_query_energy (s_query_energy),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop)
    );

    tli_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mu_result (m_mu_result),
        .m_status    (m_status)
    );

endmodule

@@ tb/table_linear_interpolator_checker.sv @@
// Checker: mirrors the interpolation table, predicts each result and compares it.
module table_linear_interpolator_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tli_pkg::PADDR_W-1:0]   paddr,
    input  logic [tli_pkg::PDATA_W-1:0]   pwdata,
    input  logic [tli_pkg::PDATA_W-1:0]   prdata,
    input  logic                          pready,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_operation,
    input  logic [tli_pkg::INDEX_W-1:0]   s_point_index,
    input  logic [tli_pkg::DATA_W-1:0]    s_point_energy,
    input  logic [tli_pkg::DATA_W-1:0]    s_point_mu,
    input  logic [tli_pkg::DATA_W-1:0]    s_query_energy,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [tli_pkg::DATA_W-1:0]    m_mu_result,
    input  logic [tli_pkg::STATUS_W-1:0]  m_status,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tli_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]   mu;
        logic [STATUS_W-1:0] status;
    } answer_t;

    logic [DATA_W-1:0] point_energy [TABLE_DEPTH];
    logic [DATA_W-1:0] point_mu     [TABLE_DEPTH];
    logic [PIU_W-1:0]  points_in_use;
    answer_t           pending_answers [$];
    int                errors = 0;

    function automatic logic [DATA_W-1:0] segment_mu(input logic [DATA_W-1:0] x0, x1, y0, y1, e);
        logic [DATA_W-1:0] dx;
        logic [63:0]       off, dy, q;
        dx = x1 - x0;
        if (dx == '0) return y0;
        off = {32'b0, e - x0};
        if (y1 >= y0) begin
            dy = {32'b0, y1 - y0};
            q  = (off * dy) / {32'b0, dx};
            return y0 + q[DATA_W-1:0];
        end
        dy = {32'b0, y0 - y1};
        q  = (off * dy) / {32'b0, dx};
        return y0 - q[DATA_W-1:0];
    endfunction

    function automatic answer_t lookup(input logic [DATA_W-1:0] e);
        answer_t a;
        int      n;
        bit      found;
        a.mu     = '0;
        a.status = STATUS_OK;
        found    = 0;
        n = (int'(points_in_use) > TABLE_DEPTH) ? TABLE_DEPTH : int'(points_in_use);
        if (n < 2) begin
            a.status = STATUS_SHORT;
        end else if (e < point_energy[0] || e > point_energy[n-1]) begin
            a.status = STATUS_RANGE;
        end else begin
            for (int i = 0; i + 1 < n && !found; i++) begin
                if (e >= point_energy[i] && e <= point_energy[i+1]) begin
                    a.mu  = segment_mu(point_energy[i], point_energy[i+1],
                                       point_mu[i], point_mu[i+1], e);
                    found = 1;
                end
            end
            if (!found) a.mu = point_mu[n-1];
        end
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            points_in_use = '0;
            pending_answers.delete();
        end else begin
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_POINTS_IN_USE) begin
                if (pwrite) begin
                    points_in_use = pwdata[PIU_W-1:0];
                end else if (prdata !== PDATA_W'(points_in_use)) begin
                    $display("%0t: points_in_use read expected %h actual %h",
                             $time, PDATA_W'(points_in_use), prdata);
                    errors++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_operation == OP_WRITE) begin
                    point_energy[s_point_index] = s_point_energy;
                    point_mu[s_point_index]     = s_point_mu;
                    want.mu     = '0;
                    want.status = STATUS_OK;
                end else begin
                    want = lookup(s_query_energy);
                end
                pending_answers.insert(pending_answers.size(), want);
            end
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual mu %h status %h",
                             $time, m_mu_result, m_status);
                    errors++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_mu_result !== want.mu) begin
                        $display("%0t: mu_result expected %h actual %h",
                                 $time, want.mu, m_mu_result);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %h actual %h",
                                 $time, want.status, m_status);
                        errors++;
                    end
                end
            end
        end
        outstanding <= pending_answers.size();
        mismatches  <= errors;
    end

endmodule

@@ tb/table_linear_interpolator_core_test.sv @@
// Top of the interpolator testbench: clock, reset, stimulus and verdict.
module table_linear_interpolator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tli_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1450;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel, penable, pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata, prdata;
    logic                 pready;
    logic                 s_valid, s_ready, s_operation;
    logic [INDEX_W-1:0]   s_point_index;
    logic [DATA_W-1:0]    s_point_energy, s_point_mu, s_query_energy;
    logic                 m_valid, m_ready;
    logic [DATA_W-1:0]    m_mu_result;
    logic [STATUS_W-1:0]  m_status;

    int                   mismatches, outstanding;
    int                   idle_cycles;
    int                   writes_sent, queries_sent, settings_done;
    bit                   idling_on;
    logic [DATA_W-1:0]    table_energy_seen [TABLE_DEPTH];
    int                   active_points;

    table_linear_interpolator_core dut (.*);

    table_linear_interpolator_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] pe, pm, qe);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_point_index  <= idx;
        s_point_energy <= pe;
        s_point_mu     <= pm;
        s_query_energy <= qe;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_WRITE) begin
            table_energy_seen[idx] = pe;
            writes_sent++;
        end else begin
            queries_sent++;
        end
    endtask

    task automatic put_point(input int idx, input logic [DATA_W-1:0] pe, pm);
        send_item(OP_WRITE, INDEX_W'(idx), pe, pm, $urandom());
    endtask

    task automatic ask(input logic [DATA_W-1:0] e);
        send_item(OP_QUERY, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                  $urandom(), $urandom(), e);
    endtask

    // hold off the sender until every outstanding result has left
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_points(input int count);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_POINTS_IN_USE, 2'b00};
        pwdata  <= PDATA_W'(count);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        active_points = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        settings_done++;
    endtask

    // ascending energies from a random base; optional repeats and full-range ends
    task automatic load_table(input int count, input int span, input bit repeats,
                              input bit full_range);
        logic [63:0]       acc;
        logic [DATA_W-1:0] e;
        acc = full_range ? 64'd0 : 64'($urandom_range(0, 1000));
        for (int i = 0; i < count; i++) begin
            e = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[DATA_W-1:0];
            if (full_range && i == count - 1) e = 32'hFFFF_FFFF;
            put_point(i, e, $urandom());
            if (!(repeats && $urandom_range(0, 5) == 0)) acc += $urandom_range(1, span);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_energy();
        int                r, i;
        logic [DATA_W-1:0] lo, hi;
        logic [63:0]       off;
        r = $urandom_range(0, 99);
        if (active_points < 2 || r >= 95) return $urandom();
        if (r < 75) begin
            i  = $urandom_range(0, active_points - 2);
            lo = table_energy_seen[i];
            hi = table_energy_seen[i+1];
            if (hi < lo) return lo;
            off = {$urandom(), $urandom()} % ({32'b0, hi} - {32'b0, lo} + 64'd1);
            return lo + off[DATA_W-1:0];
        end
        if (r < 87) return table_energy_seen[$urandom_range(0, active_points - 1)];
        if (r < 91) return table_energy_seen[0] - 1;
        return table_energy_seen[active_points - 1] + 1;
    endfunction

    initial begin
        int phase, pick, count, span, nq;
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_operation    <= OP_WRITE;
        s_point_index  <= '0;
        s_point_energy <= '0;
        s_point_mu     <= '0;
        s_query_energy <= '0;
        idling_on      <= 1'b1;
        writes_sent    = 0;
        queries_sent   = 0;
        settings_done  = 0;
        active_points  = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: short table, range edges, zero-width and falling segments
        ask(32'd0);
        put_point(0, 32'd100, 32'h0001_0000);
        put_point(1, 32'd100, 32'h0002_0000);
        put_point(2, 32'd300, 32'h0008_0000);
        put_point(3, 32'd400, 32'h0000_0000);
        set_points(1);
        ask(32'd150);
        set_points(4);
        ask(32'd99);
        ask(32'd401);
        ask(32'd100);
        ask(32'd200);
        ask(32'd350);
        ask(32'd400);
        put_point(1, 32'd500, 32'h0007_0000);
        ask(32'd450);
        ask(32'd350);
        put_point(0, 32'd0, 32'hFFFF_FFFF);
        put_point(1, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_WRITE, '1, '1, '1, '1);
        set_points(2);
        ask(32'd0);
        ask(32'hFFFF_FFFF);
        send_item(OP_QUERY, '1, '1, '1, 32'h7FFF_FFFF);

        // random phases: load a sorted table, then mostly in-range lookups
        phase = 0;
        while (writes_sent + queries_sent < RANDOM_ITEMS + 21) begin
            if (writes_sent + queries_sent > RANDOM_ITEMS - 130) idling_on <= 1'b0;
            pick = $urandom_range(0, 19);
            if (phase == 0 || pick == 2)  count = TABLE_DEPTH;
            else if (phase == 1)          count = 127;
            else if (pick == 0)           count = 0;
            else if (pick == 1)           count = 1;
            else if (pick == 3)           count = $urandom_range(65, 127);
            else if (pick < 7)            count = $urandom_range(11, 40);
            else                          count = $urandom_range(2, 10);
            case ($urandom_range(0, 3))
                0:       span = 3;
                1:       span = 1000;
                2:       span = 1 << 20;
                default: span = 1 << 26;
            endcase
            set_points(count);
            load_table(active_points, span, $urandom_range(0, 2) == 0,
                       $urandom_range(0, 5) == 0);
            nq = $urandom_range(8, 30);
            for (int k = 0; k < nq; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    put_point($urandom_range(0, TABLE_DEPTH - 1), $urandom(), $urandom());
                end else begin
                    ask(pick_energy());
                end
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("covered %0d point writes and %0d lookups over %0d table settings",
                 writes_sent, queries_sent, settings_done);
        $display("settings ranged from an empty table to 127 points, clamped to %0d",
                 TABLE_DEPTH);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/tli_front.sv
rtl/tli_back.sv
rtl/table_linear_interpolator_core.sv
tb/table_linear_interpolator_checker.sv
tb/table_linear_interpolator_core_test.sv
